### hdl/pavs_pkg.sv
// Package for the polygon area vector sum block: widths, queue word type,
// back-end state enum and small saturation helpers.
// No dependencies; imported by every module under hdl/.
package pavs_pkg;

    localparam int COORD_BITS     = 16;
    localparam int PROD_BITS      = 2 * COORD_BITS;
    localparam int CROSS_BITS     = PROD_BITS + 1;
    localparam int SUM_BITS       = 42;
    localparam int TOTAL_BITS     = 48;
    localparam int AREA_BITS      = 46;
    localparam int HALF_BITS      = SUM_BITS / 2;
    localparam int ACC_BITS       = 2 * SUM_BITS;
    localparam int RAD_BITS       = 2 * AREA_BITS;
    localparam int REM_BITS       = AREA_BITS + 3;
    localparam int IN_TDATA_BITS  = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((AREA_BITS + TOTAL_BITS + 7) / 8) * 8;
    localparam int FIFO_DEPTH_DEF = 4;

    // one finished ring, as handed from front to back
    typedef struct packed {
        logic                       pend;
        logic signed [SUM_BITS-1:0] sx;
        logic signed [SUM_BITS-1:0] sy;
        logic signed [SUM_BITS-1:0] sz;
    } t_ring_sum;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_DRAIN,
        ST_ROOT,
        ST_TOTAL
    } t_back_state;

    function automatic logic signed [SUM_BITS-1:0] sat_sum(
        input logic signed [SUM_BITS:0] v
    );
        logic signed [SUM_BITS-1:0] r;
        if (v[SUM_BITS] != v[SUM_BITS-1]) begin
            r = v[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            r = v[SUM_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [TOTAL_BITS-1:0] sat_total(
        input logic signed [TOTAL_BITS:0] v
    );
        logic signed [TOTAL_BITS-1:0] r;
        if (v[TOTAL_BITS] != v[TOTAL_BITS-1]) begin
            r = v[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                              : {1'b0, {(TOTAL_BITS-1){1'b1}}};
        end else begin
            r = v[TOTAL_BITS-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/polygon_area_vector_sum_3d.sv
// Polygon area from 3D vertex stream, top level.
// Slave channel s_axis: one vertex word a cycle while s_axis_tready is high,
// tdata = {z, y, x} (16-bit signed each), tlast marks the closing vertex of
// a ring, tuser marks the last ring of a polygon (only looked at with tlast).
// Master channel m_axis: one word per ring, tdata = {pad, polygon_area,
// ring_area}, tlast set when the ring closed its polygon. Areas are Q4.
// Config: i_cfg_wr_en/i_cfg_wr_data write use_depth (reset 1); 0 takes every
// z as zero for a planar area. Write only while the block is idle.
// Vertices are taken every cycle while s_axis_tready is high; a ring end is
// written to the ring queue in the cycle after it is accepted. Per ring the
// back end pops and loads, issues nine 21x21 partial products plus a drain,
// runs the 46-step bit-serial square root and updates the total. The square
// root sets the ring rate; rings closing faster than the back end finishes
// them fill the queue (FIFO_DEPTH rings) and then s_axis_tready drops until
// a slot frees.
// A result waits in the output register while m_axis_tready is low; the back
// end holds its next result, the queue and front keep working.
// Reset (synchronous, active low) empties the queue, clears the running
// total and starts a new polygon with an exterior ring.
module polygon_area_vector_sum_3d #(
    parameter int FIFO_DEPTH = pavs_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pavs_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,   // x, y, z
    input  logic                                s_axis_tlast,   // ring_end
    input  logic                                s_axis_tuser,   // polygon_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pavs_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,   // ring_area, polygon_area
    output logic                                m_axis_tlast    // last
);
    import pavs_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic          w_push, w_pop, w_empty;
    t_ring_sum     w_push_data, w_pop_data;
    logic [CW-1:0] w_count;

    pavs_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .i_fifo_count  (w_count),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    pavs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_count     (w_count),
        .o_empty     (w_empty)
    );

    pavs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_pop_data    (w_pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### hdl/pavs_front.sv
// Front end: takes vertex words, keeps the previous vertex and accumulates
// the cross-product sum of each ring; pushes finished rings to the queue.
// Depends on pavs_pkg.
module pavs_front #(
    parameter int FIFO_DEPTH = pavs_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_wr_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pavs_pkg::IN_TDATA_BITS-1:0] s_axis_tdata,   // x, y, z
    input  logic                               s_axis_tlast,   // ring end
    input  logic                               s_axis_tuser,   // polygon end
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]    i_fifo_count,
    output logic                               o_push,
    output pavs_pkg::t_ring_sum                o_push_data
);
    import pavs_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic                         r_use_depth;
    logic signed [COORD_BITS-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic                         r_start;
    logic                         r_s1_valid, r_s1_first, r_s1_rend, r_s1_pend;
    logic signed [PROD_BITS-1:0]  r_p [6];
    logic signed [SUM_BITS-1:0]   r_sx, r_sy, r_sz;

    logic                         w_accept;
    logic signed [COORD_BITS-1:0] w_cx, w_cy, w_cz;
    logic signed [PROD_BITS-1:0]  w_p [6];
    logic signed [CROSS_BITS-1:0] w_kx, w_ky, w_kz;
    logic signed [SUM_BITS-1:0]   n_sx, n_sy, n_sz;

    // a ring end already in stage 1 will take one queue slot next cycle
    assign s_axis_tready = ((CW+1)'(i_fifo_count) + (CW+1)'(r_s1_rend)) < (CW+1)'(FIFO_DEPTH);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_cx = s_axis_tdata[COORD_BITS-1:0];
        w_cy = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        w_cz = r_use_depth ? s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS] : '0;
    end

    // cur x prev, six partial products
    assign w_p[0] = w_cy * r_prev_z;
    assign w_p[1] = w_cz * r_prev_y;
    assign w_p[2] = w_cz * r_prev_x;
    assign w_p[3] = w_cx * r_prev_z;
    assign w_p[4] = w_cx * r_prev_y;
    assign w_p[5] = w_cy * r_prev_x;

    always_comb begin
        w_kx = CROSS_BITS'(r_p[0]) - CROSS_BITS'(r_p[1]);
        w_ky = CROSS_BITS'(r_p[2]) - CROSS_BITS'(r_p[3]);
        w_kz = CROSS_BITS'(r_p[4]) - CROSS_BITS'(r_p[5]);
        if (r_s1_first) begin
            n_sx = '0;
            n_sy = '0;
            n_sz = '0;
        end else begin
            n_sx = sat_sum((SUM_BITS+1)'(r_sx) + (SUM_BITS+1)'(w_kx));
            n_sy = sat_sum((SUM_BITS+1)'(r_sy) + (SUM_BITS+1)'(w_ky));
            n_sz = sat_sum((SUM_BITS+1)'(r_sz) + (SUM_BITS+1)'(w_kz));
        end
    end

    assign o_push           = r_s1_valid && r_s1_rend;
    assign o_push_data.pend = r_s1_pend;
    assign o_push_data.sx   = n_sx;
    assign o_push_data.sy   = n_sy;
    assign o_push_data.sz   = n_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_depth <= 1'b1;
            r_start     <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_s1_rend   <= 1'b0;
            r_sx        <= '0;
            r_sy        <= '0;
            r_sz        <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_use_depth <= i_cfg_wr_data;
            end
            r_s1_valid <= w_accept;
            r_s1_rend  <= w_accept && s_axis_tlast;
            if (w_accept) begin
                r_start  <= s_axis_tlast;
                r_prev_x <= w_cx;
                r_prev_y <= w_cy;
                r_prev_z <= w_cz;
            end
            if (r_s1_valid) begin
                r_sx <= n_sx;
                r_sy <= n_sy;
                r_sz <= n_sz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_first <= r_start;
            r_s1_pend  <= s_axis_tuser;
            for (int i = 0; i < 6; i++) begin
                r_p[i] <= w_p[i];
            end
        end
    end

endmodule

### hdl/pavs_fifo.sv
// Ring queue between front and back: small memory with registered read.
// Depends on pavs_pkg.
module pavs_fifo #(
    parameter int DEPTH = pavs_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  pavs_pkg::t_ring_sum          i_push_data,
    input  logic                         i_pop,
    output pavs_pkg::t_ring_sum          o_pop_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output logic                         o_empty
);
    import pavs_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_ring_sum       r_mem [DEPTH];
    t_ring_sum       r_rd_data;
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_pop_data = r_rd_data;
    assign o_count    = r_count;
    assign o_empty    = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)) || i_pop)
        else $error("ring queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("ring queue underflow");
`endif

endmodule

### hdl/pavs_back.sv
// Back end: squares the ring sum over a shared 21x21 multiplier, takes the
// integer square root one bit per cycle, updates the polygon total and
// holds the result word for the output. Depends on pavs_pkg.
module pavs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    output logic                                o_pop,
    input  pavs_pkg::t_ring_sum                 i_pop_data,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [pavs_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,  // ring_area, polygon_area
    output logic                                m_axis_tlast   // polygon closed
);
    import pavs_pkg::*;

    localparam int CNT_BITS = $clog2(AREA_BITS);
    localparam int SH_BITS  = $clog2(SUM_BITS + 1);

    t_back_state r_state, n_state;

    logic                         r_pend;
    logic [SUM_BITS-1:0]          r_mag_x, r_mag_y, r_mag_z;
    logic [1:0]                   r_comp, r_part;
    logic [SUM_BITS-1:0]          r_prod;
    logic [SH_BITS-1:0]           r_prod_sh;
    logic                         r_prod_valid;
    logic [ACC_BITS-1:0]          r_acc;
    logic [RAD_BITS-1:0]          r_rad;
    logic [REM_BITS-1:0]          r_rem;
    logic [AREA_BITS-1:0]         r_root;
    logic [CNT_BITS-1:0]          r_cnt;
    logic signed [TOTAL_BITS-1:0] r_total;
    logic                         r_ext;
    logic                         r_out_valid, r_out_last;
    logic [AREA_BITS-1:0]         r_out_area;
    logic signed [TOTAL_BITS-1:0] r_out_total;

    logic                         w_issue, w_out_load, w_last_issue;
    logic [SUM_BITS-1:0]          w_m;
    logic [HALF_BITS-1:0]         w_op_a, w_op_b;
    logic [SH_BITS-1:0]           w_sh;
    logic [ACC_BITS-1:0]          w_acc_next;
    logic [REM_BITS-1:0]          w_rem_sh, w_trial;
    logic signed [TOTAL_BITS:0]   w_t;
    logic signed [TOTAL_BITS-1:0] w_total_sat;

    function automatic logic [SUM_BITS-1:0] mag(input logic signed [SUM_BITS-1:0] v);
        return v[SUM_BITS-1] ? SUM_BITS'(-v) : SUM_BITS'(v);
    endfunction

    assign w_last_issue = (r_comp == 2'd2) && (r_part == 2'd2);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_empty) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_MUL;
            ST_MUL:   if (w_last_issue) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_ROOT;
            ST_ROOT:  if (r_cnt == CNT_BITS'(AREA_BITS - 1)) n_state = ST_TOTAL;
            ST_TOTAL: if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop      = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_pop = !i_empty;
            ST_MUL:   w_issue = 1'b1;
            ST_TOTAL: w_out_load = !r_out_valid || m_axis_tready;
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // m^2 = hi^2 << 42 + 2*hi*lo << 21 + lo^2
    always_comb begin
        case (r_comp)
            2'd0:    w_m = r_mag_x;
            2'd1:    w_m = r_mag_y;
            default: w_m = r_mag_z;
        endcase
        case (r_part)
            2'd0: begin
                w_op_a = w_m[HALF_BITS-1:0];
                w_op_b = w_m[HALF_BITS-1:0];
                w_sh   = '0;
            end
            2'd1: begin
                w_op_a = w_m[SUM_BITS-1:HALF_BITS];
                w_op_b = w_m[HALF_BITS-1:0];
                w_sh   = SH_BITS'(HALF_BITS + 1);
            end
            default: begin
                w_op_a = w_m[SUM_BITS-1:HALF_BITS];
                w_op_b = w_m[SUM_BITS-1:HALF_BITS];
                w_sh   = SH_BITS'(SUM_BITS);
            end
        endcase
    end

    assign w_acc_next = r_prod_valid ? r_acc + (ACC_BITS'(r_prod) << r_prod_sh) : r_acc;

    // restoring square root, two radicand bits per step
    assign w_rem_sh = {r_rem[REM_BITS-3:0], r_rad[RAD_BITS-1 -: 2]};
    assign w_trial  = REM_BITS'({r_root, 2'b01});

    always_comb begin
        if (r_ext) begin
            w_t = (TOTAL_BITS+1)'(r_total) + $signed({3'b000, r_root});
        end else begin
            w_t = (TOTAL_BITS+1)'(r_total) - $signed({3'b000, r_root});
        end
        w_total_sat = sat_total(w_t);
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_out_total, r_out_area});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prod_valid <= 1'b0;
            r_total      <= '0;
            r_ext        <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prod_valid <= w_issue;
            if (w_out_load) begin
                r_total     <= r_pend ? '0 : w_total_sat;
                r_ext       <= r_pend;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            r_pend  <= i_pop_data.pend;
            r_mag_x <= mag(i_pop_data.sx);
            r_mag_y <= mag(i_pop_data.sy);
            r_mag_z <= mag(i_pop_data.sz);
            r_comp  <= '0;
            r_part  <= '0;
            r_acc   <= '0;
        end else begin
            r_acc <= w_acc_next;
        end
        if (w_issue) begin
            r_prod    <= w_op_a * w_op_b;
            r_prod_sh <= w_sh;
            if (r_part == 2'd2) begin
                r_part <= '0;
                r_comp <= r_comp + 1'b1;
            end else begin
                r_part <= r_part + 1'b1;
            end
        end
        if (r_state == ST_DRAIN) begin
            // times 64 for Q4 of the half length
            r_rad  <= RAD_BITS'({w_acc_next, 6'b0});
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_ROOT) begin
            r_rad <= r_rad << 2;
            r_cnt <= r_cnt + 1'b1;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[AREA_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[AREA_BITS-2:0], 1'b0};
            end
        end
        if (w_out_load) begin
            r_out_area  <= r_root;
            r_out_total <= w_total_sat;
            r_out_last  <= r_pend;
        end
    end

`ifndef SYNTH
    a_load_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($past(r_state) == ST_IDLE))
        else $error("load without a queue pop");

    a_rad_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT && n_state == ST_TOTAL) |=> (r_rad == '0))
        else $error("root finished with radicand bits left");

    a_exterior_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_ext) |=> (r_out_total == {2'b00, r_out_area}))
        else $error("exterior ring total differs from its area");
`endif

endmodule
